// ----- design/quintic_joint_trajectory_sample_macros.svh -----
// Assertion helpers for the trajectory sampler.
`ifndef QUINTIC_JOINT_TRAJECTORY_SAMPLE_MACROS_SVH
`define QUINTIC_JOINT_TRAJECTORY_SAMPLE_MACROS_SVH

`ifndef SYNTHESIS
`define QJTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define QJTS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define QJTS_ASSERT(lbl, prop, msg)
`define QJTS_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- design/qjts_pkg.sv -----
package qjts_pkg;

  localparam int unsigned ANGLE_W = 24;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned RATE_W  = 32;

  localparam logic [STEP_W-1:0] MAX_STEPS  = 16'd65535;
  localparam logic [RATE_W-1:0] PERIOD_RST = 32'd655;

endpackage

// ----- design/qjts_if.sv -----
interface qjts_sample_if;
  import qjts_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] start_angle;
  logic signed [ANGLE_W-1:0] goal_angle;
  logic [STEP_W-1:0]         step_index;
  logic [TIME_W-1:0]         segment_duration;
  logic [TIME_W-1:0]         segment_start_time;

  modport source (
    output valid, start_angle, goal_angle, step_index, segment_duration,
           segment_start_time,
    input  ready
  );
  modport sink (
    input  valid, start_angle, goal_angle, step_index, segment_duration,
           segment_start_time,
    output ready
  );
endinterface

interface qjts_result_if;
  import qjts_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [TIME_W-1:0]         stamp_time;
  logic signed [ANGLE_W-1:0] position_out;
  logic signed [31:0]        velocity_out;
  logic signed [31:0]        accel_out;
  logic                      last_sample;
  logic                      bad_duration;

  modport source (
    output valid, stamp_time, position_out, velocity_out, accel_out, last_sample,
           bad_duration,
    input  ready
  );
  modport sink (
    input  valid, stamp_time, position_out, velocity_out, accel_out, last_sample,
           bad_duration,
    output ready
  );
endinterface

// ----- design/quintic_joint_trajectory_sample.sv -----
// Quintic minimum-jerk trajectory sampler. Each transaction on sample_i asks for one sample
// of one joint; one transaction on result_o returns timestamp, position, velocity,
// acceleration and the last-sample and bad-duration flags. Throughput is one transaction per
// cycle while the output queue has room. The pipe holds bit-per-stage dividers for the step
// count, tau and local time, and velocity and acceleration quotients. A two-entry output
// queue lets the pipe keep taking input while a result waits; input stalls only once both
// entries are full. The user must write sample_period via cfg_we_i/cfg_wdata_i only while
// the block is idle, which the block does not enforce; a zero period acts as one.
`include "quintic_joint_trajectory_sample_macros.svh"

module quintic_joint_trajectory_sample (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qjts_pkg::RATE_W-1:0]    cfg_wdata_i,
  qjts_sample_if.sink                    sample_i,
  qjts_result_if.source                  result_o
);
  import qjts_pkg::*;

  localparam int unsigned ND_STEPS  = STEP_W;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned PW_STAGES = 4;
  localparam int unsigned ST_LD0    = ND_STEPS + 3;
  localparam int unsigned ST_LD_END = ST_LD0 + DIV_STEPS;
  localparam int unsigned NSTG      = ST_LD_END + 1 + PW_STAGES + 3 + DIV_STEPS + 2;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] start;
    logic signed [ANGLE_W-1:0] goal;
    logic [TIME_W-1:0]         dur;
    logic [TIME_W-1:0]         t0;
    logic                      bad;
  } ctx_t;

  typedef struct packed {
    ctx_t              ctx;
    logic [STEP_W-1:0] step;
  } in_t;

  typedef struct packed {
    ctx_t              ctx;
    logic [STEP_W-1:0] step;
    logic              sat;
    logic [RATE_W-1:0] rem;
    logic [STEP_W-1:0] lo;
    logic [STEP_W-1:0] q;
  } nd_t;

  typedef struct packed {
    ctx_t              ctx;
    logic [STEP_W-1:0] n;
    logic [STEP_W-1:0] k;
    logic              last;
  } ks_t;

  typedef struct packed {
    ctx_t              ctx;
    logic [STEP_W-1:0] n;
    logic              last;
    logic [STEP_W-1:0] lrem;
    logic [31:0]       llo;
    logic [31:0]       lq;
    logic [STEP_W-1:0] trem;
    logic [31:0]       tlo;
    logic [31:0]       tq;
  } ld_t;

  typedef struct packed {
    ctx_t        ctx;
    logic        last;
    logic [31:0] stamp;
    logic [30:0] t;
    logic [30:0] t2;
    logic [30:0] t3;
    logic [30:0] t4;
    logic [30:0] t5;
  } pw_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] start;
    logic [TIME_W-1:0]         dur;
    logic                      bad;
    logic                      last;
    logic [31:0]               stamp;
    logic [30:0]               s;
    logic [31:0]               r;
    logic signed [33:0]        a;
    logic signed [ANGLE_W:0]   disp;
  } pl_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] start;
    logic [TIME_W-1:0]         dur;
    logic                      bad;
    logic                      last;
    logic [31:0]               stamp;
    logic signed [56:0]        sd;
    logic signed [57:0]        rd;
    logic signed [58:0]        ad;
    logic [63:0]               dd;
  } md_t;

  typedef struct packed {
    logic                      bad;
    logic                      last;
    logic [31:0]               stamp;
    logic signed [ANGLE_W-1:0] pos;
    logic                      vneg;
    logic [55:0]               vnum;
    logic [45:0]               vden;
    logic                      aneg;
    logic [63:0]               anum;
    logic [63:0]               aden;
  } rn_t;

  typedef struct packed {
    logic                      bad;
    logic                      last;
    logic [31:0]               stamp;
    logic signed [ANGLE_W-1:0] pos;
    logic                      vneg;
    logic                      vovf;
    logic [45:0]               vrem;
    logic [31:0]               vlo;
    logic [31:0]               vq;
    logic [45:0]               vden;
    logic                      aneg;
    logic                      aovf;
    logic [63:0]               arem;
    logic [31:0]               alo;
    logic [31:0]               aq;
    logic [63:0]               aden;
  } vd_t;

  typedef struct packed {
    logic [TIME_W-1:0]         stamp_time;
    logic signed [ANGLE_W-1:0] position_out;
    logic signed [31:0]        velocity_out;
    logic signed [31:0]        accel_out;
    logic                      last_sample;
    logic                      bad_duration;
  } res_t;

  function automatic logic [32:0] nd_step(logic [31:0] rem, logic b, logic [31:0] d);
    logic [32:0] sh;
    logic [32:0] df;
    sh = {rem, b};
    df = sh - {1'b0, d};
    if (sh >= {1'b0, d}) return {1'b1, df[31:0]};
    else return {1'b0, sh[31:0]};
  endfunction

  function automatic logic [16:0] ld_step(logic [15:0] rem, logic b, logic [15:0] d);
    logic [16:0] sh;
    logic [16:0] df;
    sh = {rem, b};
    df = sh - {1'b0, d};
    if (sh >= {1'b0, d}) return {1'b1, df[15:0]};
    else return {1'b0, sh[15:0]};
  endfunction

  function automatic logic [46:0] v_step(logic [45:0] rem, logic b, logic [45:0] d);
    logic [46:0] sh;
    logic [46:0] df;
    sh = {rem, b};
    df = sh - {1'b0, d};
    if (sh >= {1'b0, d}) return {1'b1, df[45:0]};
    else return {1'b0, sh[45:0]};
  endfunction

  function automatic logic [64:0] a_step(logic [63:0] rem, logic b, logic [63:0] d);
    logic [64:0] sh;
    logic [64:0] df;
    sh = {rem, b};
    df = sh - {1'b0, d};
    if (sh >= {1'b0, d}) return {1'b1, df[63:0]};
    else return {1'b0, sh[63:0]};
  endfunction

  // Q30 product, result never above one while both operands are at most one
  function automatic logic [30:0] mulq(logic [30:0] a, logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b);
    return p[60:30];
  endfunction

  function automatic logic [31:0] sat32(logic neg, logic ovf, logic [31:0] q);
    if (neg) begin
      if (ovf || q > 32'h8000_0000) return 32'h8000_0000;
      else return 32'(-q);
    end else begin
      if (ovf || q > 32'h7FFF_FFFF) return 32'h7FFF_FFFF;
      else return q;
    end
  endfunction

  logic [RATE_W-1:0] period_q;
  logic [RATE_W-1:0] per;
  logic              en;
  logic [NSTG-1:0]   vld_q;
  logic [1:0]        cnt_q;
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic              push;
  logic              pop;

  in_t  in_q;
  nd_t  nd_q [ND_STEPS+1];
  ks_t  ks_q;
  ld_t  ld_q [DIV_STEPS+1];
  pw_t  pw_q [PW_STAGES];
  pw_t  pw_d [PW_STAGES];
  pl_t  pl_q;
  pl_t  pl_d;
  md_t  md_q;
  rn_t  rn_q;
  rn_t  rn_d;
  vd_t  vd_q [DIV_STEPS+1];
  res_t out_q;
  res_t out_d;
  res_t fifo_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  assign per = (period_q == '0) ? RATE_W'(1) : period_q;

  assign en             = (cnt_q != 2'd2);
  assign sample_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], sample_i.valid};
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q.ctx.start <= sample_i.start_angle;
      in_q.ctx.goal  <= sample_i.goal_angle;
      in_q.ctx.dur   <= sample_i.segment_duration;
      in_q.ctx.t0    <= sample_i.segment_start_time;
      in_q.ctx.bad   <= (sample_i.segment_duration == '0);
      in_q.step      <= sample_i.step_index;
    end
  end

  // step count: ceil(dur / per), saturating
  logic [RATE_W:0] num;
  assign num = {1'b0, in_q.ctx.dur} + {1'b0, per} - 33'd1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nd_q[0].ctx  <= in_q.ctx;
      nd_q[0].step <= in_q.step;
      nd_q[0].sat  <= (RATE_W'(num[RATE_W:STEP_W]) >= per);
      nd_q[0].rem  <= RATE_W'(num[RATE_W:STEP_W]);
      nd_q[0].lo   <= num[STEP_W-1:0];
      nd_q[0].q    <= '0;
    end
  end

  for (genvar j = 1; j <= ND_STEPS; j++) begin : g_nd
    logic [32:0] r;
    assign r = nd_step(nd_q[j-1].rem, nd_q[j-1].lo[STEP_W-1], per);
    always_ff @(posedge clk_i) begin
      if (en) begin
        nd_q[j].ctx  <= nd_q[j-1].ctx;
        nd_q[j].step <= nd_q[j-1].step;
        nd_q[j].sat  <= nd_q[j-1].sat;
        nd_q[j].rem  <= r[31:0];
        nd_q[j].lo   <= {nd_q[j-1].lo[STEP_W-2:0], 1'b0};
        nd_q[j].q    <= {nd_q[j-1].q[STEP_W-2:0], r[32]};
      end
    end
  end

  logic [STEP_W-1:0] n_c;
  always_comb begin
    if (nd_q[ND_STEPS].sat || nd_q[ND_STEPS].q > MAX_STEPS) n_c = MAX_STEPS;
    else if (nd_q[ND_STEPS].q == '0) n_c = STEP_W'(1);
    else n_c = nd_q[ND_STEPS].q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ks_q.ctx  <= nd_q[ND_STEPS].ctx;
      ks_q.n    <= n_c;
      ks_q.k    <= (nd_q[ND_STEPS].step < n_c) ? nd_q[ND_STEPS].step : n_c;
      ks_q.last <= (nd_q[ND_STEPS].step >= n_c);
    end
  end

  // local time k*dur/n and tau k*2^30/n share the divider stages
  logic [47:0] kd;
  assign kd = 48'(ks_q.k) * 48'(ks_q.ctx.dur);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ld_q[0].ctx  <= ks_q.ctx;
      ld_q[0].n    <= ks_q.n;
      ld_q[0].last <= ks_q.last;
      ld_q[0].lrem <= kd[47:32];
      ld_q[0].llo  <= kd[31:0];
      ld_q[0].lq   <= '0;
      ld_q[0].trem <= {2'b00, ks_q.k[STEP_W-1:2]};
      ld_q[0].tlo  <= {ks_q.k[1:0], 30'd0};
      ld_q[0].tq   <= '0;
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_ld
    logic [16:0] rl;
    logic [16:0] rt;
    assign rl = ld_step(ld_q[j-1].lrem, ld_q[j-1].llo[31], ld_q[j-1].n);
    assign rt = ld_step(ld_q[j-1].trem, ld_q[j-1].tlo[31], ld_q[j-1].n);
    always_ff @(posedge clk_i) begin
      if (en) begin
        ld_q[j].ctx  <= ld_q[j-1].ctx;
        ld_q[j].n    <= ld_q[j-1].n;
        ld_q[j].last <= ld_q[j-1].last;
        ld_q[j].lrem <= rl[15:0];
        ld_q[j].llo  <= {ld_q[j-1].llo[30:0], 1'b0};
        ld_q[j].lq   <= {ld_q[j-1].lq[30:0], rl[16]};
        ld_q[j].trem <= rt[15:0];
        ld_q[j].tlo  <= {ld_q[j-1].tlo[30:0], 1'b0};
        ld_q[j].tq   <= {ld_q[j-1].tq[30:0], rt[16]};
      end
    end
  end

  // powers of tau, one multiply per stage
  logic [32:0] stamp_sum;
  assign stamp_sum = {1'b0, ld_q[DIV_STEPS].ctx.t0} + {1'b0, ld_q[DIV_STEPS].lq};

  always_comb begin
    pw_d[0].ctx   = ld_q[DIV_STEPS].ctx;
    pw_d[0].last  = ld_q[DIV_STEPS].last;
    pw_d[0].stamp = stamp_sum[32] ? 32'hFFFF_FFFF : stamp_sum[31:0];
    pw_d[0].t     = ld_q[DIV_STEPS].tq[30:0];
    pw_d[0].t2    = mulq(ld_q[DIV_STEPS].tq[30:0], ld_q[DIV_STEPS].tq[30:0]);
    pw_d[0].t3    = '0;
    pw_d[0].t4    = '0;
    pw_d[0].t5    = '0;
    pw_d[1]       = pw_q[0];
    pw_d[1].t3    = mulq(pw_q[0].t2, pw_q[0].t);
    pw_d[2]       = pw_q[1];
    pw_d[2].t4    = mulq(pw_q[1].t3, pw_q[1].t);
    pw_d[3]       = pw_q[2];
    pw_d[3].t5    = mulq(pw_q[2].t4, pw_q[2].t);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_q <= pw_d;
    end
  end

  // blend polynomials and their derivatives
  always_comb begin
    logic signed [39:0] t1e, t2e, t3e, t4e, t5e, s40, r40, a40;
    t1e = $signed({9'd0, pw_q[3].t});
    t2e = $signed({9'd0, pw_q[3].t2});
    t3e = $signed({9'd0, pw_q[3].t3});
    t4e = $signed({9'd0, pw_q[3].t4});
    t5e = $signed({9'd0, pw_q[3].t5});
    s40 = 40'sd10 * t3e - 40'sd15 * t4e + 40'sd6 * t5e;
    r40 = 40'sd30 * t2e - 40'sd60 * t3e + 40'sd30 * t4e;
    a40 = 40'sd60 * t1e - 40'sd180 * t2e + 40'sd120 * t3e;
    pl_d.start = pw_q[3].ctx.start;
    pl_d.dur   = pw_q[3].ctx.dur;
    pl_d.bad   = pw_q[3].ctx.bad;
    pl_d.last  = pw_q[3].last;
    pl_d.stamp = pw_q[3].stamp;
    if (s40 < 0) pl_d.s = '0;
    else if (s40 > 40'sd1073741824) pl_d.s = 31'h4000_0000;
    else pl_d.s = s40[30:0];
    pl_d.r    = (r40 < 0) ? '0 : r40[31:0];
    pl_d.a    = a40[33:0];
    pl_d.disp = 25'(pw_q[3].ctx.goal) - 25'(pw_q[3].ctx.start);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pl_q <= pl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q.start <= pl_q.start;
      md_q.dur   <= pl_q.dur;
      md_q.bad   <= pl_q.bad;
      md_q.last  <= pl_q.last;
      md_q.stamp <= pl_q.stamp;
      md_q.sd    <= 57'($signed({1'b0, pl_q.s})) * 57'(pl_q.disp);
      md_q.rd    <= 58'($signed({1'b0, pl_q.r})) * 58'(pl_q.disp);
      md_q.ad    <= 59'(pl_q.a) * 59'(pl_q.disp);
      md_q.dd    <= 64'(pl_q.dur) * 64'(pl_q.dur);
    end
  end

  // position rounding, magnitudes and half-divisor offsets
  always_comb begin
    logic signed [56:0] w;
    logic signed [27:0] ps;
    logic [57:0]        vm;
    logic [58:0]        am;
    w  = md_q.sd + 57'sd536870912;
    ps = 28'(w >>> 30) + 28'(md_q.start);
    vm = (md_q.rd < 0) ? 58'(-md_q.rd) : 58'(md_q.rd);
    am = (md_q.ad < 0) ? 59'(-md_q.ad) : 59'(md_q.ad);
    rn_d.bad   = md_q.bad;
    rn_d.last  = md_q.last;
    rn_d.stamp = md_q.stamp;
    if (ps > 28'sd8388607) rn_d.pos = 24'sh7F_FFFF;
    else if (ps < -28'sd8388608) rn_d.pos = 24'sh80_0000;
    else rn_d.pos = ps[23:0];
    rn_d.vneg = (md_q.rd < 0);
    rn_d.vnum = vm[55:0] + 56'({md_q.dur, 13'd0});
    rn_d.vden = {md_q.dur, 14'd0};
    rn_d.aneg = (md_q.ad < 0);
    rn_d.anum = 64'({am, 2'b00}) + (md_q.dd >> 1);
    rn_d.aden = md_q.dd;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rn_q <= rn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vd_q[0].bad   <= rn_q.bad;
      vd_q[0].last  <= rn_q.last;
      vd_q[0].stamp <= rn_q.stamp;
      vd_q[0].pos   <= rn_q.pos;
      vd_q[0].vneg  <= rn_q.vneg;
      vd_q[0].vovf  <= (46'(rn_q.vnum[55:32]) >= rn_q.vden);
      vd_q[0].vrem  <= 46'(rn_q.vnum[55:32]);
      vd_q[0].vlo   <= rn_q.vnum[31:0];
      vd_q[0].vq    <= '0;
      vd_q[0].vden  <= rn_q.vden;
      vd_q[0].aneg  <= rn_q.aneg;
      vd_q[0].aovf  <= (64'(rn_q.anum[63:32]) >= rn_q.aden);
      vd_q[0].arem  <= 64'(rn_q.anum[63:32]);
      vd_q[0].alo   <= rn_q.anum[31:0];
      vd_q[0].aq    <= '0;
      vd_q[0].aden  <= rn_q.aden;
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_vd
    logic [46:0] rv;
    logic [64:0] ra;
    vd_t         vd_d;
    assign rv = v_step(vd_q[j-1].vrem, vd_q[j-1].vlo[31], vd_q[j-1].vden);
    assign ra = a_step(vd_q[j-1].arem, vd_q[j-1].alo[31], vd_q[j-1].aden);
    always_comb begin
      vd_d      = vd_q[j-1];
      vd_d.vrem = rv[45:0];
      vd_d.vlo  = {vd_q[j-1].vlo[30:0], 1'b0};
      vd_d.vq   = {vd_q[j-1].vq[30:0], rv[46]};
      vd_d.arem = ra[63:0];
      vd_d.alo  = {vd_q[j-1].alo[30:0], 1'b0};
      vd_d.aq   = {vd_q[j-1].aq[30:0], ra[64]};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        vd_q[j] <= vd_d;
      end
    end
  end

  always_comb begin
    out_d = '0;
    if (vd_q[DIV_STEPS].bad) begin
      out_d.bad_duration = 1'b1;
    end else begin
      out_d.stamp_time   = vd_q[DIV_STEPS].stamp;
      out_d.position_out = vd_q[DIV_STEPS].pos;
      out_d.velocity_out = sat32(vd_q[DIV_STEPS].vneg, vd_q[DIV_STEPS].vovf,
                                 vd_q[DIV_STEPS].vq);
      out_d.accel_out    = sat32(vd_q[DIV_STEPS].aneg, vd_q[DIV_STEPS].aovf,
                                 vd_q[DIV_STEPS].aq);
      out_d.last_sample  = vd_q[DIV_STEPS].last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // two-entry output queue
  assign push = en & vld_q[NSTG-1];
  assign pop  = result_o.valid & result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= out_q;
    end
  end

  assign result_o.valid        = (cnt_q != 2'd0);
  assign result_o.stamp_time   = fifo_q[rd_ptr_q].stamp_time;
  assign result_o.position_out = fifo_q[rd_ptr_q].position_out;
  assign result_o.velocity_out = fifo_q[rd_ptr_q].velocity_out;
  assign result_o.accel_out    = fifo_q[rd_ptr_q].accel_out;
  assign result_o.last_sample  = fifo_q[rd_ptr_q].last_sample;
  assign result_o.bad_duration = fifo_q[rd_ptr_q].bad_duration;

  logic res_zero;
  assign res_zero = (result_o.velocity_out == '0) && (result_o.accel_out == '0) &&
                    (result_o.position_out == '0) && (result_o.stamp_time == '0);

  `QJTS_ASSERT(a_cnt_range, cnt_q != 2'd3, "output queue count out of range")
  `QJTS_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_q), "pipe moved while stalled")
  `QJTS_ASSERT(a_steps_nonzero, !vld_q[ST_LD0] || ld_q[0].n != '0, "step count is zero")
  `QJTS_ASSERT(a_tau_range, !vld_q[ST_LD_END] || ld_q[DIV_STEPS].tq <= 32'h4000_0000, "tau above one")
  `QJTS_ASSERT(a_bad_zero, !(result_o.valid && result_o.bad_duration) || res_zero, "bad duration result not cleared")

endmodule
